// ===== hdl/setm_pkg.sv =====
// Shared types and constants for the Sobel edge threshold mask unit.
`default_nettype none

package setm_pkg;

    localparam int RGB_W         = 8;
    localparam int GREY_W        = 8;
    localparam int ROW_W         = 13;
    localparam int OUT_COL_W     = 10;
    localparam int OUT_ROW_W     = 12;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 13;
    localparam int FWIDTH_CFG_W  = 11;
    localparam int MAX_HEIGHT    = 4096;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;

    // grey = (30r + 59g + 11b) / 100, divide done as multiply by 5243 >> 19
    localparam int GREY_SUM_W    = 15;
    localparam int GREY_PROD_W   = 28;
    localparam int GREY_KR       = 30;
    localparam int GREY_KG       = 59;
    localparam int GREY_KB       = 11;
    localparam int DIV100_MUL    = 5243;
    localparam int DIV100_SHIFT  = 19;

    localparam int SUM_W         = 10;
    localparam int DIFF_W        = 11;
    localparam int MAG_W         = 22;
    localparam int EDGE_LIMIT    = 20014;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 8'd0,
        REG_FRAME_HEIGHT = 8'd1
    } cfg_reg_t;

    typedef logic [GREY_W-1:0] grey_t;

    typedef struct packed {
        grey_t older;
        grey_t newer;
    } line_entry_t;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } win_mask_t;

    typedef struct packed {
        logic                 prod;
        logic                 last;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        win_mask_t            mask;
    } pix_info_t;

endpackage

`default_nettype wire

// ===== hdl/sobel_edge_threshold_mask_unit.sv =====
// Sobel edge mask top level: position tracking, pipeline control and result register.
// Throughput: one request per cycle; each stage holds only while the one after it is full.
// Results pass the input, line-store, window and output registers in that order; the pixel
// at raster position q is answered by request q + frame_width + 1.
// Reset clears handshake state, position counters and restores 640x480; line stores are not
// cleared, since entries from before the current frame are never used unmasked.
`default_nettype none

module sobel_edge_threshold_mask_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [setm_pkg::S_TDATA_W-1:0]      s_tdata,   // red, green, blue
    input  logic                                s_tuser,   // flush
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [setm_pkg::M_TDATA_W-1:0]      m_tdata,   // edge_res, col, row, zero pad
    output logic                                m_tlast,   // last_of_frame
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [setm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [setm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import setm_pkg::*;

    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int WID_W         = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_RST_EFF = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    // configuration
    logic [WID_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [WID_W-1:0] width_next;
    logic [ROW_W-1:0] height_next;
    logic [31:0]      w_raw;
    logic             cfg_w_hit;
    logic             cfg_h_hit;

    // position
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] in_col_next;
    logic [ROW_W-1:0] in_row_next;
    logic [WID_W-1:0] col_ext;
    logic [WID_W-1:0] col_inc;
    logic [WID_W-1:0] ccol;
    logic [ROW_W-1:0] crow;
    logic             frame_end;
    pix_info_t        info_in;

    // pipeline
    logic             rdy_a, rdy_b, rdy_c, rdy_d;
    logic             acc_in, en_b, en_c;
    logic             va_reg, vb_reg, vc_reg, vd_reg;
    logic [RGB_W-1:0] red_a_reg, green_a_reg, blue_a_reg;
    logic             flush_a_reg;
    logic [COL_W-1:0] col_a_reg;
    pix_info_t        info_a_reg, info_b_reg, info_c_reg;
    logic             edge_d_reg;
    logic             last_d_reg;
    logic [OUT_COL_W-1:0] col_d_reg;
    logic [OUT_ROW_W-1:0] row_d_reg;

    grey_t            grey_a;
    grey_t            grey_b;
    grey_t            tap_mid;
    grey_t            tap_top;
    logic             is_edge;

    assign cfg_ready = 1'b1;
    assign cfg_w_hit = cfg_valid && (cfg_index == REG_FRAME_WIDTH);
    assign cfg_h_hit = cfg_valid && (cfg_index == REG_FRAME_HEIGHT);

    always_comb
    begin
        w_raw = 32'(cfg_data[FWIDTH_CFG_W-1:0]);
        if (w_raw == 32'd0)
        begin
            w_raw = 32'd1;
        end
        else if (w_raw > 32'(MAX_WIDTH))
        begin
            w_raw = 32'(MAX_WIDTH);
        end
        width_next = w_raw[WID_W-1:0];

        if (cfg_data == '0)
        begin
            height_next = ROW_W'(1);
        end
        else if (cfg_data > ROW_W'(MAX_HEIGHT))
        begin
            height_next = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            height_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(WIDTH_RST_EFF);
            height_reg <= ROW_W'(HEIGHT_RST);
        end
        else
        begin
            if (cfg_w_hit)
            begin
                width_reg <= width_next;
            end
            if (cfg_h_hit)
            begin
                height_reg <= height_next;
            end
        end
    end

    // position of this request and of the window centre it completes
    always_comb
    begin
        col_ext   = WID_W'(in_col_reg);
        col_inc   = col_ext + WID_W'(1);
        frame_end = (in_row_reg == height_reg + ROW_W'(1));

        if (in_col_reg == '0)
        begin
            ccol = width_reg - WID_W'(1);
            crow = in_row_reg - ROW_W'(2);
        end
        else
        begin
            ccol = col_ext - WID_W'(1);
            crow = in_row_reg - ROW_W'(1);
        end

        info_in.prod = (in_row_reg > ROW_W'(1)) ||
                       ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        info_in.last = (crow == height_reg - ROW_W'(1)) &&
                       (ccol == width_reg - WID_W'(1));
        info_in.col  = OUT_COL_W'(ccol);
        info_in.row  = OUT_ROW_W'(crow);
        info_in.mask.top_ok   = (crow != '0);
        info_in.mask.bot_ok   = (crow != height_reg - ROW_W'(1));
        info_in.mask.left_ok  = (ccol != '0);
        info_in.mask.right_ok = (ccol != width_reg - WID_W'(1));

        if (frame_end)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
        else if (col_inc == width_reg)
        begin
            in_col_next = '0;
            in_row_next = in_row_reg + ROW_W'(1);
        end
        else
        begin
            in_col_next = col_inc[COL_W-1:0];
            in_row_next = in_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (cfg_w_hit || cfg_h_hit)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (acc_in)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    // stage handshake
    assign rdy_d  = !vd_reg || m_tready;
    assign rdy_c  = !vc_reg || rdy_d;
    assign rdy_b  = !vb_reg || rdy_c;
    assign rdy_a  = !va_reg || rdy_b;
    assign s_tready = rdy_a;
    assign acc_in = s_tvalid && rdy_a;
    assign en_b   = va_reg && rdy_b;
    assign en_c   = vb_reg && rdy_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= s_tvalid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
            if (rdy_c)
            begin
                vc_reg <= vb_reg;
            end
            if (rdy_d)
            begin
                vd_reg <= vc_reg && info_c_reg.prod;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            red_a_reg   <= s_tdata[RGB_W-1:0];
            green_a_reg <= s_tdata[2*RGB_W-1:RGB_W];
            blue_a_reg  <= s_tdata[3*RGB_W-1:2*RGB_W];
            flush_a_reg <= s_tuser;
            col_a_reg   <= in_col_reg;
            info_a_reg  <= info_in;
        end
        if (en_b)
        begin
            info_b_reg <= info_a_reg;
        end
        if (en_c)
        begin
            info_c_reg <= info_b_reg;
        end
        if (rdy_d)
        begin
            edge_d_reg <= is_edge;
            last_d_reg <= info_c_reg.last;
            col_d_reg  <= info_c_reg.col;
            row_d_reg  <= info_c_reg.row;
        end
    end

    setm_grey u_grey (
        .red   (red_a_reg),
        .green (green_a_reg),
        .blue  (blue_a_reg),
        .flush (flush_a_reg),
        .grey  (grey_a)
    );

    setm_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_b),
        .addr     (col_a_reg),
        .grey_in  (grey_a),
        .grey_out (grey_b),
        .tap_mid  (tap_mid),
        .tap_top  (tap_top)
    );

    setm_window u_window (
        .clk     (clk),
        .en      (en_c),
        .top_in  (tap_top),
        .mid_in  (tap_mid),
        .bot_in  (grey_b),
        .mask    (info_c_reg.mask),
        .is_edge (is_edge)
    );

    assign m_tvalid = vd_reg;
    assign m_tdata  = {1'b0, row_d_reg, col_d_reg, edge_d_reg};
    assign m_tlast  = last_d_reg;

endmodule

`default_nettype wire

// ===== hdl/setm_grey.sv =====
// RGB to grey conversion with divide by 100 through a reciprocal multiply.
`default_nettype none

module setm_grey (
    input  logic [setm_pkg::RGB_W-1:0] red,
    input  logic [setm_pkg::RGB_W-1:0] green,
    input  logic [setm_pkg::RGB_W-1:0] blue,
    input  logic                       flush,
    output setm_pkg::grey_t            grey
);
    import setm_pkg::*;

    logic [GREY_SUM_W-1:0]  wsum;
    logic [GREY_PROD_W-1:0] scaled;

    assign wsum = GREY_SUM_W'(GREY_KR) * GREY_SUM_W'(red)
                + GREY_SUM_W'(GREY_KG) * GREY_SUM_W'(green)
                + GREY_SUM_W'(GREY_KB) * GREY_SUM_W'(blue);

    assign scaled = GREY_PROD_W'(wsum) * GREY_PROD_W'(DIV100_MUL);

    assign grey = flush ? '0 : scaled[DIV100_SHIFT +: GREY_W];

endmodule

`default_nettype wire

// ===== hdl/setm_line_buf.sv =====
// Two-line grey history: one memory holding the two older rows per column.
`default_nettype none

module setm_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  setm_pkg::grey_t   grey_in,
    output setm_pkg::grey_t   grey_out,
    output setm_pkg::grey_t   tap_mid,
    output setm_pkg::grey_t   tap_top
);
    import setm_pkg::*;

    line_entry_t       mem [DEPTH];
    line_entry_t       rd_reg;
    line_entry_t       byp_reg;
    logic              hit_reg;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    grey_t             grey_reg;

    line_entry_t       rd_data;
    line_entry_t       wr_data;

    // write-back lands in the cycle after the read; bypass covers a same-column read
    assign rd_data = hit_reg ? byp_reg : rd_reg;
    assign wr_data = '{older: rd_data.newer, newer: grey_reg};

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            mem[wr_addr_reg] <= wr_data;
        end
        if (en)
        begin
            rd_reg      <= mem[addr];
            byp_reg     <= wr_data;
            grey_reg    <= grey_in;
            wr_addr_reg <= addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= en;
            if (en)
            begin
                hit_reg <= wr_pend_reg && (addr == wr_addr_reg);
            end
        end
    end

    assign grey_out = grey_reg;
    assign tap_mid  = rd_data.newer;
    assign tap_top  = rd_data.older;

endmodule

`default_nettype wire

// ===== hdl/setm_window.sv =====
// 3x3 grey window, Sobel sums and squared-magnitude threshold.
`default_nettype none

module setm_window (
    input  logic                clk,
    input  logic                en,
    input  setm_pkg::grey_t     top_in,
    input  setm_pkg::grey_t     mid_in,
    input  setm_pkg::grey_t     bot_in,
    input  setm_pkg::win_mask_t mask,
    output logic                is_edge
);
    import setm_pkg::*;

    grey_t win_reg [3][3];  // [column][row], column 0 is left, row 0 is top
    grey_t m [3][3];

    logic [SUM_W-1:0]         lsum;
    logic [SUM_W-1:0]         rsum;
    logic [SUM_W-1:0]         tsum;
    logic [SUM_W-1:0]         bsum;
    logic signed [DIFF_W-1:0] s1;
    logic signed [DIFF_W-1:0] s2;
    logic [MAG_W-1:0]         mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= top_in;
            win_reg[2][1] <= mid_in;
            win_reg[2][2] <= bot_in;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if ((c == 0 && !mask.left_ok) || (c == 2 && !mask.right_ok) ||
                    (r == 0 && !mask.top_ok) || (r == 2 && !mask.bot_ok))
                begin
                    m[c][r] = '0;
                end
                else
                begin
                    m[c][r] = win_reg[c][r];
                end
            end
        end
    end

    assign lsum = SUM_W'(m[0][0]) + SUM_W'({m[0][1], 1'b0}) + SUM_W'(m[0][2]);
    assign rsum = SUM_W'(m[2][0]) + SUM_W'({m[2][1], 1'b0}) + SUM_W'(m[2][2]);
    assign bsum = SUM_W'(m[0][2]) + SUM_W'({m[1][2], 1'b0}) + SUM_W'(m[2][2]);
    assign tsum = SUM_W'(m[0][0]) + SUM_W'({m[1][0], 1'b0}) + SUM_W'(m[2][0]);

    assign s1 = $signed({1'b0, lsum}) - $signed({1'b0, rsum});
    assign s2 = $signed({1'b0, bsum}) - $signed({1'b0, tsum});

    assign mag = MAG_W'(MAG_W'(s1) * MAG_W'(s1)) + MAG_W'(MAG_W'(s2) * MAG_W'(s2));

    assign is_edge = (mag >= MAG_W'(EDGE_LIMIT));

endmodule

`default_nettype wire
